// ----- design/assert_macros.svh -----
// Assertion macros shared by the transmit queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property with synchronous reset masking.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must never be seen on a clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_AT(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- design/uttx_pkg.sv -----
// Shared types and constants for the UART transmit byte queue.
package uttx_pkg;

  // Command codes of an input transaction
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_TXE = 1'b1;

  localparam int FILL_W      = 10;
  localparam int DROP_W      = 32;
  localparam int BYTE_W      = 8;

  // Result queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic              send_valid;
    logic              accepted;
    logic [DROP_W-1:0] dropped_count;
    logic [FILL_W-1:0] fill_level;
    logic              irq_armed;
  } job_t;

  // Complete result item
  typedef struct packed {
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              accepted;
    logic [DROP_W-1:0] dropped_count;
    logic [FILL_W-1:0] fill_level;
    logic              irq_armed;
  } res_t;

endpackage

// ----- design/uttx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module uttx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- design/uttx_front.sv -----
// Front end: accepts transactions, keeps queue pointers, counters and irq flag.
module uttx_front #(
  parameter int DEPTH = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_cmd,
  input  logic [uttx_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic [uttx_pkg::QCNT_W-1:0]          q_cnt,
  output logic                                 ram_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
  output logic [uttx_pkg::BYTE_W-1:0]          ram_wdata,
  output logic                                 ram_re,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
  output logic                                 job_vld_r,
  output uttx_pkg::job_t                       job_r
);
  import uttx_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]     wa_r, wa_nxt;
  logic [AW-1:0]     ra_r, ra_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic              irq_r, irq_nxt;
  logic              job_vld_nxt;
  job_t              job_nxt;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [QCNT_W:0]   inflight;

  // Back-pressure: results queued plus the one in flight must fit the queue
  assign inflight = {1'b0, q_cnt} + {{QCNT_W{1'b0}}, job_vld_r};
  assign in_full  = inflight >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_push && !in_full;

  assign is_full  = cnt_r == CW'(DEPTH);
  assign is_empty = cnt_r == '0;

  // Classify the transaction and compute next state
  always_comb begin
    wa_nxt      = wa_r;
    ra_nxt      = ra_r;
    cnt_nxt     = cnt_r;
    drop_nxt    = drop_r;
    irq_nxt     = irq_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    job_nxt     = '0;
    job_vld_nxt = accept;
    if (accept) begin
      case (in_cmd)
        CMD_ENQ: begin
          if (is_full) begin
            drop_nxt = drop_r + 1'b1;
          end else begin
            ram_we           = 1'b1;
            wa_nxt           = (wa_r == AW'(DEPTH - 1)) ? '0 : wa_r + 1'b1;
            cnt_nxt          = cnt_r + 1'b1;
            irq_nxt          = 1'b1;
            job_nxt.accepted = 1'b1;
          end
        end
        CMD_TXE: begin
          if (irq_r) begin
            if (!is_empty) begin
              ram_re             = 1'b1;
              ra_nxt             = (ra_r == AW'(DEPTH - 1)) ? '0 : ra_r + 1'b1;
              cnt_nxt            = cnt_r - 1'b1;
              job_nxt.send_valid = 1'b1;
            end else begin
              irq_nxt = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    job_nxt.dropped_count = drop_nxt;
    job_nxt.fill_level    = FILL_W'(cnt_nxt);
    job_nxt.irq_armed     = irq_nxt;
  end

  assign ram_waddr = wa_r;
  assign ram_wdata = in_data_byte;
  assign ram_raddr = ra_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r      <= '0;
      ra_r      <= '0;
      cnt_r     <= '0;
      drop_r    <= '0;
      irq_r     <= 1'b0;
      job_vld_r <= 1'b0;
    end else begin
      wa_r      <= wa_nxt;
      ra_r      <= ra_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      irq_r     <= irq_nxt;
      job_vld_r <= job_vld_nxt;
    end
  end

  // Job payload, lines up with the RAM read data
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

// ----- design/uttx_back.sv -----
// Back end: merges read data into results and queues them for the consumer.
module uttx_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_vld,
  input  uttx_pkg::job_t              job,
  input  logic [uttx_pkg::BYTE_W-1:0] ram_rdata,
  input  logic                        out_pop,
  output logic                        out_empty,
  output uttx_pkg::res_t              head,
  output logic [uttx_pkg::QCNT_W-1:0] q_cnt
);
  import uttx_pkg::*;

  res_t              q_mem [QUEUE_DEPTH];
  res_t              item;
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  // Build the result; byte reads as zero when nothing is sent
  always_comb begin
    item.send_valid    = job.send_valid;
    item.send_byte     = job.send_valid ? ram_rdata : '0;
    item.accepted      = job.accepted;
    item.dropped_count = job.dropped_count;
    item.fill_level    = job.fill_level;
    item.irq_armed     = job.irq_armed;
  end

  assign pop       = out_pop && (cnt_r != '0);
  assign out_empty = cnt_r == '0;
  assign head      = q_mem[rp_r];
  assign q_cnt     = cnt_r;

  // Pointer and occupancy update
  always_comb begin
    wp_nxt  = job_vld ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{(QCNT_W - 1){1'b0}}, job_vld} - {{(QCNT_W - 1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    if (job_vld) begin
      q_mem[wp_r] <= item;
    end
  end

endmodule

// ----- design/uart_tx_ring_drop_on_full_core.sv -----
// Transmit byte queue core: holds up to DEPTH bytes in one RAM (no clearing pass
// after reset). One transaction per cycle is sustained as long as results are
// popped; each result passes through the RAM's registered read and then the
// four-entry result queue. in_full rises when that result queue plus the
// transaction in flight fill it, so the input rate is set by how fast the
// consumer pops. Enqueues into a full queue are dropped and counted;
// transmitter-empty events hand out bytes while armed.
`include "assert_macros.svh"

module uart_tx_ring_drop_on_full_core #(
  parameter int DEPTH = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_cmd,
  input  logic [uttx_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_send_valid,
  output logic [uttx_pkg::BYTE_W-1:0]   out_send_byte,
  output logic                          out_accepted,
  output logic [uttx_pkg::DROP_W-1:0]   out_dropped_count,
  output logic [uttx_pkg::FILL_W-1:0]   out_fill_level,
  output logic                          out_irq_armed
);
  import uttx_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              job_vld;
  job_t              job;
  res_t              head;
  logic [QCNT_W-1:0] q_cnt;

  // Byte store
  uttx_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  // Accept and classify
  uttx_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (push),
    .in_full     (full),
    .in_cmd      (in_cmd),
    .in_data_byte(in_data_byte),
    .q_cnt       (q_cnt),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .job_vld_r   (job_vld),
    .job_r       (job)
  );

  // Result assembly and queue
  uttx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_vld  (job_vld),
    .job      (job),
    .ram_rdata(ram_rdata),
    .out_pop  (pop),
    .out_empty(empty),
    .head     (head),
    .q_cnt    (q_cnt)
  );

  assign out_send_valid    = head.send_valid;
  assign out_send_byte     = head.send_byte;
  assign out_accepted      = head.accepted;
  assign out_dropped_count = head.dropped_count;
  assign out_fill_level    = head.fill_level;
  assign out_irq_armed     = head.irq_armed;

  // A job never lands in a full result queue unless a pop makes room
  `ASSERT_NEVER(a_no_overrun, clk, rst_n, job_vld && (q_cnt == QCNT_W'(QUEUE_DEPTH)) && !pop, "result queue overrun")
  // A byte is only handed out while the interrupt stays armed
  `ASSERT_NEVER(a_send_armed, clk, rst_n, !empty && out_send_valid && !out_irq_armed, "byte sent while disarmed")
  // A stored byte always arms the interrupt and never sends in the same step
  `ASSERT_NEVER(a_acc_arms, clk, rst_n, !empty && out_accepted && (!out_irq_armed || out_send_valid), "accepted without arming")
  // Accepting a transaction always produces a job on the next cycle
  `ASSERT_AT(a_job_follows, clk, rst_n, (push && !full) |=> job_vld, "job missing after accept")

endmodule
